>>> hw/rtl/cspt_pkg.sv
// Shared types and constants of the capsule support point test core.
package cspt_pkg;

    localparam int RADIUS_W    = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int NSTAGES     = 6;
    localparam int OUT_TDATA_W = 8;

    localparam logic [RADIUS_W-1:0] RADIUS_SQ_RST = 24'd671089;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_X        = 3'd0,
        CFG_LEFT_Y        = 3'd1,
        CFG_RIGHT_X       = 3'd2,
        CFG_RIGHT_Y       = 3'd3,
        CFG_LEFT_PRESENT  = 3'd4,
        CFG_RIGHT_PRESENT = 3'd5,
        CFG_RADIUS_SQ     = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_LEFT  = 2'd1,
        MODE_RIGHT = 2'd2,
        MODE_BOTH  = 2'd3
    } t_mode;

    typedef struct packed {
        logic [NSTAGES-1:0] load;
        logic [NSTAGES-1:0] valid;
    } t_pipe_ctl;

endpackage

>>> hw/rtl/cspt_cfg.sv
// Configuration register file of the capsule support point test core.
module cspt_cfg #(
    parameter int COORD_BITS = 20,
    parameter int CFG_W      = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [cspt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0]                     i_cfg_data,
    output logic signed [COORD_BITS-1:0]         o_left_x,
    output logic signed [COORD_BITS-1:0]         o_left_y,
    output logic signed [COORD_BITS-1:0]         o_right_x,
    output logic signed [COORD_BITS-1:0]         o_right_y,
    output logic [cspt_pkg::RADIUS_W-1:0]        o_radius_sq,
    output cspt_pkg::t_mode                      o_mode
);

    logic signed [COORD_BITS-1:0]  r_left_x;
    logic signed [COORD_BITS-1:0]  r_left_y;
    logic signed [COORD_BITS-1:0]  r_right_x;
    logic signed [COORD_BITS-1:0]  r_right_y;
    logic                          r_left_present;
    logic                          r_right_present;
    logic [cspt_pkg::RADIUS_W-1:0] r_radius_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_x        <= '0;
            r_left_y        <= '0;
            r_right_x       <= '0;
            r_right_y       <= '0;
            r_left_present  <= 1'b0;
            r_right_present <= 1'b0;
            r_radius_sq     <= cspt_pkg::RADIUS_SQ_RST;
        end else if (i_cfg_we) begin
            unique case (cspt_pkg::t_cfg_idx'(i_cfg_idx))
                cspt_pkg::CFG_LEFT_X:        r_left_x        <= i_cfg_data[COORD_BITS-1:0];
                cspt_pkg::CFG_LEFT_Y:        r_left_y        <= i_cfg_data[COORD_BITS-1:0];
                cspt_pkg::CFG_RIGHT_X:       r_right_x       <= i_cfg_data[COORD_BITS-1:0];
                cspt_pkg::CFG_RIGHT_Y:       r_right_y       <= i_cfg_data[COORD_BITS-1:0];
                cspt_pkg::CFG_LEFT_PRESENT:  r_left_present  <= i_cfg_data[0];
                cspt_pkg::CFG_RIGHT_PRESENT: r_right_present <= i_cfg_data[0];
                cspt_pkg::CFG_RADIUS_SQ:
                    r_radius_sq <= i_cfg_data[cspt_pkg::RADIUS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_left_x    = r_left_x;
    assign o_left_y    = r_left_y;
    assign o_right_x   = r_right_x;
    assign o_right_y   = r_right_y;
    assign o_radius_sq = r_radius_sq;
    assign o_mode      = cspt_pkg::t_mode'({r_right_present, r_left_present});

endmodule

>>> hw/rtl/cspt_pipe_ctl.sv
// Valid and stall control of the capsule support point test pipeline.
module cspt_pipe_ctl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output cspt_pkg::t_pipe_ctl o_ctl
);

    localparam int N = cspt_pkg::NSTAGES;

    logic [N-1:0] r_valid;
    logic [N-1:0] n_valid;
    logic [N-1:0] en;
    logic [N-1:0] load;

    always_comb begin
        en[N-1] = !r_valid[N-1] || i_out_ready;
        for (int k = N - 2; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
        load[0]    = en[0] && i_in_valid;
        n_valid[0] = en[0] ? i_in_valid : r_valid[0];
        for (int k = 1; k < N; k++) begin
            load[k]    = en[k] && r_valid[k-1];
            n_valid[k] = en[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = en[0];
    assign o_ctl.load  = load;
    assign o_ctl.valid = r_valid;

`ifndef SYNTHESIS
    logic [N-1:0] hold;
    assign hold = r_valid & ~en;

    a_stalled_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|hold) |=> ((r_valid & $past(hold)) == $past(hold)))
        else $error("A stalled item left its stage.");

    a_occupancy_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !(r_valid[N-1] && i_out_ready))
        |=> ($countones(r_valid) == $past($countones(r_valid)) + 1))
        else $error("An accepted item was lost in the pipeline.");

    a_ready_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(r_valid) < N) |-> o_in_ready)
        else $error("Input stalled although the pipeline has room.");
`endif

endmodule

>>> hw/rtl/cspt_datapath.sv
// Six-stage arithmetic of the disc and capsule containment test.
module cspt_datapath #(
    parameter int COORD_BITS = 20
) (
    input  logic                          i_clk,
    input  cspt_pkg::t_pipe_ctl           i_ctl,
    input  logic signed [COORD_BITS-1:0]  i_point_x,
    input  logic signed [COORD_BITS-1:0]  i_point_y,
    input  logic signed [COORD_BITS-1:0]  i_left_x,
    input  logic signed [COORD_BITS-1:0]  i_left_y,
    input  logic signed [COORD_BITS-1:0]  i_right_x,
    input  logic signed [COORD_BITS-1:0]  i_right_y,
    input  logic [cspt_pkg::RADIUS_W-1:0] i_radius_sq,
    input  cspt_pkg::t_mode               i_mode,
    output logic                          o_inside_res,
    output cspt_pkg::t_mode               o_support_mode
);

    localparam int C  = COORD_BITS;
    localparam int D  = C + 1;
    localparam int S  = 2 * C + 2;
    localparam int W  = 2 * C + 3;
    localparam int H  = C + 1;
    localparam int RW = cspt_pkg::RADIUS_W;
    localparam int Q  = 2 * S;

    // Stage 1: differences.
    logic signed [D-1:0] r1_dxr, r1_dyr, r1_dxl, r1_dyl, r1_ux, r1_uy;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r1_dxr <= D'(i_point_x) - D'(i_right_x);
            r1_dyr <= D'(i_point_y) - D'(i_right_y);
            r1_dxl <= D'(i_point_x) - D'(i_left_x);
            r1_dyl <= D'(i_point_y) - D'(i_left_y);
            r1_ux  <= D'(i_left_x) - D'(i_right_x);
            r1_uy  <= D'(i_left_y) - D'(i_right_y);
        end
    end

    // Stage 2: products.
    logic signed [S-1:0] r2_sxr, r2_syr, r2_sxl, r2_syl, r2_sux, r2_suy;
    logic signed [S-1:0] r2_xrux, r2_yruy, r2_xruy, r2_yrux;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r2_sxr  <= r1_dxr * r1_dxr;
            r2_syr  <= r1_dyr * r1_dyr;
            r2_sxl  <= r1_dxl * r1_dxl;
            r2_syl  <= r1_dyl * r1_dyl;
            r2_sux  <= r1_ux * r1_ux;
            r2_suy  <= r1_uy * r1_uy;
            r2_xrux <= r1_dxr * r1_ux;
            r2_yruy <= r1_dyr * r1_uy;
            r2_xruy <= r1_dxr * r1_uy;
            r2_yrux <= r1_dyr * r1_ux;
        end
    end

    // Stage 3: squared lengths, dot product and cross product magnitude.
    logic [S-1:0]        r3_dr2, r3_dl2, r3_l2, r3_crs_abs;
    logic signed [W-1:0] r3_dot;
    logic signed [W-1:0] n3_crs_p, n3_crs_n;

    assign n3_crs_p = W'(r2_xruy) - W'(r2_yrux);
    assign n3_crs_n = W'(r2_yrux) - W'(r2_xruy);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r3_dr2     <= r2_sxr + r2_syr;
            r3_dl2     <= r2_sxl + r2_syl;
            r3_l2      <= r2_sux + r2_suy;
            r3_dot     <= W'(r2_xrux) + W'(r2_yruy);
            r3_crs_abs <= n3_crs_p[W-1] ? n3_crs_n[S-1:0] : n3_crs_p[S-1:0];
        end
    end

    // Stage 4: comparisons and partial products of the wide squares.
    logic              r4_nonpos, r4_beyond, r4_in_r, r4_in_l, r4_l2_zero;
    logic [2*H-1:0]    r4_chh, r4_chl, r4_cll;
    logic [RW+H-1:0]   r4_rlh, r4_rll;
    logic [S-1:0]      radius_ext;

    assign radius_ext = S'(i_radius_sq);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            r4_nonpos  <= r3_dot[W-1] || (r3_dot == '0);
            r4_beyond  <= !r3_dot[W-1] && (r3_dot > $signed({1'b0, r3_l2}));
            r4_in_r    <= r3_dr2 < radius_ext;
            r4_in_l    <= r3_dl2 < radius_ext;
            r4_l2_zero <= r3_l2 == '0;
            r4_chh     <= r3_crs_abs[S-1:H] * r3_crs_abs[S-1:H];
            r4_chl     <= r3_crs_abs[S-1:H] * r3_crs_abs[H-1:0];
            r4_cll     <= r3_crs_abs[H-1:0] * r3_crs_abs[H-1:0];
            r4_rlh     <= i_radius_sq * r3_l2[S-1:H];
            r4_rll     <= i_radius_sq * r3_l2[H-1:0];
        end
    end

    // Stage 5: sums of the partial products.
    logic         r5_nonpos, r5_beyond, r5_in_r, r5_in_l, r5_l2_zero;
    logic [Q-1:0] r5_crs2, r5_rl2;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[4]) begin
            r5_nonpos  <= r4_nonpos;
            r5_beyond  <= r4_beyond;
            r5_in_r    <= r4_in_r;
            r5_in_l    <= r4_in_l;
            r5_l2_zero <= r4_l2_zero;
            r5_crs2    <= (Q'(r4_chh) << (2 * H)) + (Q'(r4_chl) << (H + 1)) + Q'(r4_cll);
            r5_rl2     <= (Q'(r4_rlh) << H) + Q'(r4_rll);
        end
    end

    // Stage 6: decision and output register.
    logic            n6_inside;
    logic            r6_inside;
    cspt_pkg::t_mode r6_mode;

    always_comb begin
        n6_inside = 1'b0;
        unique case (i_mode)
            cspt_pkg::MODE_NONE:  n6_inside = 1'b0;
            cspt_pkg::MODE_LEFT:  n6_inside = r5_in_l;
            cspt_pkg::MODE_RIGHT: n6_inside = r5_in_r;
            cspt_pkg::MODE_BOTH: begin
                priority if (r5_l2_zero) begin
                    n6_inside = r5_in_r;
                end else if (r5_nonpos && !r5_in_r) begin
                    n6_inside = 1'b0;
                end else if (r5_beyond && !r5_in_l) begin
                    n6_inside = 1'b0;
                end else begin
                    n6_inside = !(r5_crs2 > r5_rl2);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[5]) begin
            r6_inside <= n6_inside;
            r6_mode   <= i_mode;
        end
    end

    assign o_inside_res   = r6_inside;
    assign o_support_mode = r6_mode;

endmodule

>>> hw/rtl/capsule_support_point_test_core.sv
// Top level of the capsule support point test core.
//
//  Channel   Direction  Payload (low bit first)
//  s_axis    in         point_x, point_y
//  m_axis    out        inside_res, support_mode
//  cfg       in         register index and write data, no read-back
//
// One item enters per cycle while the input is not refused; its result passes through
// one register per pipeline stage (differences, multipliers, sums, compares with partial
// products, partial sums, decision) before it is offered on m_axis.
// The synchronous reset clears all stage valid bits and returns the configuration
// to its reset values.
// A stalled result holds in the output stage while earlier stages keep filling empty
// slots, so input is refused only when all six stages are full and the result is not taken.
module capsule_support_point_test_core #(
    parameter int COORD_BITS = 20
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // point_x, point_y, zero padding
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]    i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // inside_res, support_mode, zero padding
    output logic [cspt_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    input  logic                                 i_cfg_we,
    input  logic [cspt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [((COORD_BITS > cspt_pkg::RADIUS_W) ?
                   COORD_BITS : cspt_pkg::RADIUS_W)-1:0] i_cfg_data
);

    localparam int CFG_W = (COORD_BITS > cspt_pkg::RADIUS_W) ? COORD_BITS : cspt_pkg::RADIUS_W;

    cspt_pkg::t_pipe_ctl             ctl;
    logic signed [COORD_BITS-1:0]    point_x, point_y;
    logic signed [COORD_BITS-1:0]    left_x, left_y, right_x, right_y;
    logic [cspt_pkg::RADIUS_W-1:0]   radius_sq;
    cspt_pkg::t_mode                 mode;
    logic                            inside_res;
    cspt_pkg::t_mode                 support_mode;

    assign point_x = i_s_axis_tdata[COORD_BITS-1:0];
    assign point_y = i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS];

    cspt_cfg #(
        .COORD_BITS (COORD_BITS),
        .CFG_W      (CFG_W)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_left_x    (left_x),
        .o_left_y    (left_y),
        .o_right_x   (right_x),
        .o_right_y   (right_y),
        .o_radius_sq (radius_sq),
        .o_mode      (mode)
    );

    cspt_pipe_ctl u_pipe_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_ctl       (ctl)
    );

    cspt_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_ctl          (ctl),
        .i_point_x      (point_x),
        .i_point_y      (point_y),
        .i_left_x       (left_x),
        .i_left_y       (left_y),
        .i_right_x      (right_x),
        .i_right_y      (right_y),
        .i_radius_sq    (radius_sq),
        .i_mode         (mode),
        .o_inside_res   (inside_res),
        .o_support_mode (support_mode)
    );

    assign o_m_axis_tvalid = ctl.valid[cspt_pkg::NSTAGES-1];
    assign o_m_axis_tdata  = {{(cspt_pkg::OUT_TDATA_W-3){1'b0}}, support_mode, inside_res};

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the capsule support point test core.
`timescale 1ns / 100ps

module testbench;

    localparam int COORD_W      = 20;
    localparam int IN_W         = ((2*COORD_W+7)/8)*8;
    localparam int CFG_DATA_W   =
        (COORD_W > cspt_pkg::RADIUS_W) ? COORD_W : cspt_pkg::RADIUS_W;
    localparam longint COORD_MAX  = (longint'(1) << (COORD_W-1)) - 1;
    localparam longint COORD_MIN  = -(longint'(1) << (COORD_W-1));
    localparam longint RADIUS_MAX = (longint'(1) << cspt_pkg::RADIUS_W) - 1;
    localparam logic [cspt_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;
    localparam int SINK_HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES     = cspt_pkg::NSTAGES + 14;
    localparam int CYCLE_LIMIT      = 300000;

    typedef struct {
        logic signed [COORD_W-1:0]   lx, ly, rx, ry;
        bit                          lp, rp;
        bit [cspt_pkg::RADIUS_W-1:0] r2;
    } t_support;

    typedef struct {
        logic            in_region;
        cspt_pkg::t_mode mode;
    } t_verdict;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_s_axis_tvalid = 1'b0;
    logic                                 o_s_axis_tready;
    logic [IN_W-1:0]                      i_s_axis_tdata = '0;
    logic                                 o_m_axis_tvalid;
    logic                                 i_m_axis_tready = 1'b0;
    logic [cspt_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata;
    logic                                 i_cfg_we = 1'b0;
    logic [cspt_pkg::CFG_IDX_W-1:0]       i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]                i_cfg_data = '0;

    t_support  region;
    t_verdict  pending_verdicts[$];
    longint    cur_radius;
    int        src_idle_pct = 0;
    int        sink_idle_pct = 0;
    bit        hold_sink = 1'b0;
    int        cycle_count = 0;
    int        mismatch_count = 0;
    int        items_sent = 0;
    int        results_seen = 0;
    int        settings_used = 0;
    int        inside_count = 0;
    int        mode_count[4] = '{0, 0, 0, 0};

    capsule_support_point_test_core #(
        .COORD_BITS(COORD_W)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d results outstanding.",
                     pending_verdicts.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic disc_hit(input longint px, py, cx, cy, r2);
        longint dx, dy;
        dx = px - cx;
        dy = py - cy;
        return (dx*dx + dy*dy) < r2;
    endfunction

    function automatic t_verdict predict_verdict(input logic signed [COORD_W-1:0] px_f, py_f);
        t_verdict  v;
        longint    px, py, lx, ly, rx, ry, r2;
        longint    ux, uy, dx, dy, l2, dot, crs, d2, e2;
        bit [127:0] c_mag, c_sq, r2_w, l2_w, limit_sq;
        px = longint'(px_f);
        py = longint'(py_f);
        lx = longint'(region.lx);
        ly = longint'(region.ly);
        rx = longint'(region.rx);
        ry = longint'(region.ry);
        r2 = longint'(region.r2);
        v.mode = cspt_pkg::t_mode'({region.rp, region.lp});
        v.in_region = 1'b0;
        case (v.mode)
            cspt_pkg::MODE_LEFT:  v.in_region = disc_hit(px, py, lx, ly, r2);
            cspt_pkg::MODE_RIGHT: v.in_region = disc_hit(px, py, rx, ry, r2);
            cspt_pkg::MODE_BOTH: begin
                ux = lx - rx;
                uy = ly - ry;
                l2 = ux*ux + uy*uy;
                if (l2 == 0) begin
                    v.in_region = disc_hit(px, py, rx, ry, r2);
                end else begin
                    dx = px - rx;
                    dy = py - ry;
                    dot = dx*ux + dy*uy;
                    crs = dx*uy - dy*ux;
                    d2 = dx*dx + dy*dy;
                    e2 = (px - lx)*(px - lx) + (py - ly)*(py - ly);
                    c_mag = 128'((crs < 0) ? -crs : crs);
                    c_sq = c_mag * c_mag;
                    r2_w = 128'(r2);
                    l2_w = 128'(l2);
                    limit_sq = r2_w * l2_w;
                    v.in_region = 1'b1;
                    if (dot <= 0 && d2 >= r2) begin
                        v.in_region = 1'b0;
                    end else if (dot > l2 && e2 >= r2) begin
                        v.in_region = 1'b0;
                    end else if (c_sq > limit_sq) begin
                        v.in_region = 1'b0;
                    end
                end
            end
            default: v.in_region = 1'b0;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("Mismatch at cycle %0d: %s is %0d, expected %0d.",
                 cycle_count, what, got, want);
    endtask

    always @(posedge i_clk) begin : result_check
        t_verdict want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (pending_verdicts.size() == 0) begin
                report_mismatch("unexpected result, tdata", longint'(o_m_axis_tdata), 0);
            end else begin
                want = pending_verdicts.pop_front();
                if (o_m_axis_tdata[0] !== want.in_region) begin
                    report_mismatch("inside_res", longint'(o_m_axis_tdata[0]),
                                    longint'(want.in_region));
                end
                if (o_m_axis_tdata[2:1] !== want.mode) begin
                    report_mismatch("support_mode", longint'(o_m_axis_tdata[2:1]),
                                    longint'(want.mode));
                end
                if (o_m_axis_tdata[cspt_pkg::OUT_TDATA_W-1:3] !== '0) begin
                    report_mismatch("tdata padding",
                                    longint'(o_m_axis_tdata[cspt_pkg::OUT_TDATA_W-1:3]), 0);
                end
            end
        end
    end

    initial begin : result_sink
        int n;
        @(posedge i_clk);
        forever begin
            if (hold_sink) begin
                i_m_axis_tready <= 1'b0;
                for (n = 0; n < SINK_HOLD_CYCLES; n++) @(posedge i_clk);
                hold_sink = 1'b0;
            end else if (sink_idle_pct != 0 && $urandom_range(1, 100) <= sink_idle_pct) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    function automatic logic signed [COORD_W-1:0] fit_coord(input longint v);
        if (v > COORD_MAX) return COORD_W'(COORD_MAX);
        if (v < COORD_MIN) return COORD_W'(COORD_MIN);
        return COORD_W'(v);
    endfunction

    function automatic logic signed [COORD_W-1:0] any_coord();
        logic [31:0] w;
        w = $urandom;
        return w[COORD_W-1:0];
    endfunction

    function automatic longint jitter(input longint span);
        return longint'($urandom_range(0, 2*span)) - span;
    endfunction

    task automatic cfg_write(input logic [cspt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            cspt_pkg::CFG_LEFT_X:        region.lx = data[COORD_W-1:0];
            cspt_pkg::CFG_LEFT_Y:        region.ly = data[COORD_W-1:0];
            cspt_pkg::CFG_RIGHT_X:       region.rx = data[COORD_W-1:0];
            cspt_pkg::CFG_RIGHT_Y:       region.ry = data[COORD_W-1:0];
            cspt_pkg::CFG_LEFT_PRESENT:  region.lp = data[0];
            cspt_pkg::CFG_RIGHT_PRESENT: region.rp = data[0];
            cspt_pkg::CFG_RADIUS_SQ:     region.r2 = data[cspt_pkg::RADIUS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic cfg_done();
        i_cfg_we <= 1'b0;
    endtask

    // Unused upper data bits carry noise, which the block has to ignore.
    task automatic load_support(input logic signed [COORD_W-1:0] lx, ly, rx, ry,
                                input bit lp, rp, input logic [cspt_pkg::RADIUS_W-1:0] r2);
        logic [CFG_DATA_W-1:0] noise;
        noise = CFG_DATA_W'($urandom);
        cfg_write(cspt_pkg::CFG_LEFT_X, {noise[CFG_DATA_W-1:COORD_W], lx});
        noise = CFG_DATA_W'($urandom);
        cfg_write(cspt_pkg::CFG_LEFT_Y, {noise[CFG_DATA_W-1:COORD_W], ly});
        noise = CFG_DATA_W'($urandom);
        cfg_write(cspt_pkg::CFG_RIGHT_X, {noise[CFG_DATA_W-1:COORD_W], rx});
        noise = CFG_DATA_W'($urandom);
        cfg_write(cspt_pkg::CFG_RIGHT_Y, {noise[CFG_DATA_W-1:COORD_W], ry});
        noise = CFG_DATA_W'($urandom);
        cfg_write(cspt_pkg::CFG_LEFT_PRESENT, {noise[CFG_DATA_W-1:1], lp});
        noise = CFG_DATA_W'($urandom);
        cfg_write(cspt_pkg::CFG_RIGHT_PRESENT, {noise[CFG_DATA_W-1:1], rp});
        cfg_write(cspt_pkg::CFG_RADIUS_SQ, CFG_DATA_W'(r2));
        if ($urandom_range(0, 1) != 0) begin
            cfg_write(CFG_NO_REG, CFG_DATA_W'($urandom));
        end
        cfg_done();
        settings_used++;
    endtask

    task automatic send_point(input logic signed [COORD_W-1:0] px, py);
        t_verdict v;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {py, px};
        do @(posedge i_clk); while (!o_s_axis_tready);
        v = predict_verdict(px, py);
        pending_verdicts = {pending_verdicts, v};
        items_sent++;
        mode_count[v.mode]++;
        if (v.in_region) inside_count++;
        if (src_idle_pct != 0 && $urandom_range(1, 100) <= src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_support();
        longint r, r2, bx, by, sep;
        int     pick;
        bit [1:0] m;
        pick = $urandom_range(0, 9);
        m = (pick < 1) ? cspt_pkg::MODE_NONE : (pick < 3) ? cspt_pkg::MODE_LEFT :
            (pick < 5) ? cspt_pkg::MODE_RIGHT : cspt_pkg::MODE_BOTH;
        r = longint'($urandom_range(0, 4095));
        if ($urandom_range(0, 9) == 0) r = ($urandom_range(0, 1) != 0) ? 4095 : 0;
        r2 = r*r + longint'($urandom_range(0, 2*r));
        if (r2 > RADIUS_MAX) r2 = RADIUS_MAX;
        if ($urandom_range(0, 3) == 0) begin
            bx = longint'(any_coord());
            by = longint'(any_coord());
        end else begin
            bx = jitter(65536);
            by = jitter(65536);
        end
        case ($urandom_range(0, 4))
            0:       sep = 0;
            1:       sep = 4;
            2:       sep = r + 1;
            3:       sep = 4*r + 64;
            default: sep = 200000;
        endcase
        cur_radius = r;
        load_support(fit_coord(bx + jitter(sep)), fit_coord(by + jitter(sep)),
                     fit_coord(bx), fit_coord(by), m[0], m[1], cspt_pkg::RADIUS_W'(r2));
    endtask

    // Points cluster around the feet and the segment so that both verdicts stay common.
    task automatic send_random_point();
        longint bx, by, span, t, lx, ly, rx, ry;
        int     a;
        lx = longint'(region.lx);
        ly = longint'(region.ly);
        rx = longint'(region.rx);
        ry = longint'(region.ry);
        span = cur_radius + cur_radius/2 + 2;
        a = $urandom_range(0, 9);
        if (a == 0) begin
            send_point(any_coord(), any_coord());
        end else begin
            if (a <= 3) begin
                bx = lx;
                by = ly;
            end else if (a <= 6) begin
                bx = rx;
                by = ry;
            end else begin
                t = longint'($urandom_range(0, 16));
                bx = rx + (lx - rx)*t/16;
                by = ry + (ly - ry)*t/16;
            end
            if ($urandom_range(0, 7) == 0) begin
                bx = bx + (($urandom_range(0, 1) != 0) ? cur_radius : -cur_radius);
            end else begin
                bx = bx + jitter(span);
                by = by + jitter(span);
            end
            send_point(fit_coord(bx), fit_coord(by));
        end
    endtask

    task automatic pick_idling();
        int choice[3] = '{0, 15, 40};
        src_idle_pct  = choice[$urandom_range(0, 2)];
        sink_idle_pct = choice[$urandom_range(0, 2)];
    endtask

    task automatic test_reset_state();
        src_idle_pct  = 20;
        sink_idle_pct = 20;
        send_point(0, 0);
        send_point(fit_coord(COORD_MAX), fit_coord(COORD_MIN));
        drain_results();
        // Left foot at the reset origin with the reset radius.
        cfg_write(cspt_pkg::CFG_LEFT_PRESENT, 1);
        cfg_done();
        send_point(819, 0);
        send_point(820, 0);
        drain_results();
    endtask

    task automatic test_single_foot();
        load_support(fit_coord(COORD_MIN), fit_coord(COORD_MAX), 0, 0, 1'b1, 1'b0, 0);
        send_point(fit_coord(COORD_MIN), fit_coord(COORD_MAX));
        drain_results();
        load_support(0, 0, fit_coord(COORD_MAX), fit_coord(COORD_MIN), 1'b0, 1'b1,
                     cspt_pkg::RADIUS_W'(RADIUS_MAX));
        send_point(fit_coord(COORD_MAX - 4095), fit_coord(COORD_MIN));
        send_point(fit_coord(COORD_MAX), fit_coord(COORD_MIN + 4096));
        drain_results();
    endtask

    task automatic test_capsule_edges();
        load_support(4000, 0, 0, 0, 1'b1, 1'b1, 1000000);
        send_point(2000, 999);
        send_point(2000, 1000);
        send_point(2000, -1001);
        send_point(-999, 0);
        send_point(-1000, 0);
        send_point(4999, 0);
        send_point(5000, 0);
        send_point(0, 999);
        send_point(0, 1000);
        send_point(4000, -1000);
        drain_results();
        // Coincident feet fall back to a disc around the right foot.
        load_support(100, -100, 100, -100, 1'b1, 1'b1, 2500);
        send_point(149, -100);
        send_point(150, -100);
        drain_results();
        load_support(fit_coord(COORD_MIN), fit_coord(COORD_MIN), fit_coord(COORD_MAX),
                     fit_coord(COORD_MAX), 1'b1, 1'b1, cspt_pkg::RADIUS_W'(RADIUS_MAX));
        send_point(0, 0);
        send_point(fit_coord(COORD_MIN), fit_coord(COORD_MAX));
        send_point(fit_coord(COORD_MAX), fit_coord(COORD_MAX));
        drain_results();
    endtask

    task automatic test_back_pressure();
        int k;
        load_support(3000, 500, -2000, 100, 1'b1, 1'b1, 4000000);
        cur_radius = 2000;
        src_idle_pct = 0;
        hold_sink = 1'b1;
        for (k = 0; k < 30; k++) send_random_point();
        drain_results();
    endtask

    task automatic test_random_regions(input int n_settings, input int items_each);
        int s, k;
        for (s = 0; s < n_settings; s++) begin
            random_support();
            pick_idling();
            for (k = 0; k < items_each; k++) send_random_point();
            drain_results();
        end
    endtask

    task automatic test_full_rate();
        int k;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_support();
        if (region.lp == 1'b0 || region.rp == 1'b0) begin
            @(posedge i_clk);
            load_support(region.lx, region.ly, region.rx, region.ry, 1'b1, 1'b1, region.r2);
        end
        for (k = 0; k < 250; k++) send_random_point();
        drain_results();
    endtask

    initial begin : main_sequence
        region.lx = 0;
        region.ly = 0;
        region.rx = 0;
        region.ry = 0;
        region.lp = 1'b0;
        region.rp = 1'b0;
        region.r2 = cspt_pkg::RADIUS_SQ_RST;
        cur_radius = 819;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_single_foot();
        test_capsule_edges();
        test_back_pressure();
        test_random_regions(12, 125);
        test_full_rate();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d points over %0d support settings, checked %0d results.",
                 items_sent, settings_used, results_seen);
        $display("Modes none/left/right/both: %0d/%0d/%0d/%0d; inside %0d; mismatches %0d.",
                 mode_count[0], mode_count[1], mode_count[2], mode_count[3],
                 inside_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/cspt_pkg.sv
hw/rtl/cspt_cfg.sv
hw/rtl/cspt_pipe_ctl.sv
hw/rtl/cspt_datapath.sv
hw/rtl/capsule_support_point_test_core.sv
tb/testbench.sv
